[rtl/xlrp_pkg.sv]
package xlrp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HEADER,
        PH_VOL_NAME,
        PH_VOL_PAD,
        PH_FILE_NAME,
        PH_FILE_PAD,
        PH_REC_TYPE,
        PH_REC_BODY,
        PH_AFTER_FF,
        PH_AFTER_VOL,
        PH_HALT
    } phase_t;

    typedef enum logic [3:0] {
        KIND_VOL_CHAR,
        KIND_VOL_END,
        KIND_FILE_CHAR,
        KIND_FILE_END,
        KIND_AUDIO,
        KIND_MOVIE,
        KIND_ENTRY_END,
        KIND_LIST_END,
        KIND_BAD_HEADER,
        KIND_BAD_TYPE
    } kind_t;

    localparam logic [4:0] HDR_CHECK_LEN = 5'd15;
    localparam logic [4:0] HDR_SKIP_TO   = 5'd24;
    localparam logic [4:0] PAD_LEN       = 5'd4;
    localparam logic [4:0] AUDIO_LAST    = 5'd10;
    localparam logic [4:0] MOVIE_LAST    = 5'd12;
    localparam logic [4:0] TIME_FIRST    = 5'd3;
    localparam logic [4:0] TIME_LAST     = 5'd8;
    localparam logic [4:0] SPEED_OFF     = 5'd9;

    localparam logic [7:0] REC_AUDIO = 8'h00;
    localparam logic [7:0] REC_MOVIE = 8'h01;
    localparam logic [7:0] LIST_FF   = 8'hFF;
    localparam logic [7:0] NUL       = 8'h00;

    localparam logic [7:0] HDR_TEXT [15] = '{
        8'h63, 8'h61, 8'h65, 8'h74, 8'h6C, 8'h61, 8'h20, 8'h58,
        8'h41, 8'h2D, 8'h4C, 8'h69, 8'h73, 8'h74, 8'h00
    };

    localparam int OUT_DATA_W = 80;

endpackage

[rtl/xa_list_record_parser.sv]
// A beat accepted on the slave side passes through the input register, then the
// result register, before its result shows on the master side.
// Throughput: one byte per cycle; the slave side keeps taking beats while the
// result register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous): parser waits for a beat with the first flag,
// both pipeline valids clear; time and speed bytes hold no reset value.
module xa_list_record_parser
    import xlrp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] file_byte
    input  logic [0:0]            s_tuser,   // [0] first_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] name_char, [15:8] start_minute,
                                             // [23:16] start_second, [31:24] start_frame,
                                             // [39:32] end_minute, [47:40] end_second,
                                             // [55:48] end_frame, [64:56] speed_factor,
                                             // [72:65] interleave, [79:73] zero
    output logic [3:0]            m_tuser    // [3:0] kind
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_first_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [3:0]            out_kind_reg;

    phase_t     phase_reg, phase_next, phase_eff;
    logic [4:0] count_reg, count_next, count_eff;
    logic       movie_reg, movie_next;
    logic [7:0] time_reg [6];
    logic [7:0] speed_reg;

    logic       out_free, proc;
    logic       res_valid;
    kind_t      res_kind;
    logic [7:0] res_char, res_inter;
    logic [8:0] res_speed;
    logic       time_we;
    logic [2:0] time_idx;
    logic       speed_we;
    logic [4:0] rec_last;
    logic [OUT_DATA_W-1:0] res_data;

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    assign phase_eff = in_first_reg ? PH_HEADER : phase_reg;
    assign count_eff = in_first_reg ? 5'd0 : count_reg;
    assign rec_last  = movie_reg ? MOVIE_LAST : AUDIO_LAST;
    assign time_idx  = 3'(count_eff - TIME_FIRST);

    always_comb begin
        phase_next = phase_eff;
        count_next = count_eff;
        movie_next = movie_reg;
        res_valid  = 1'b0;
        res_kind   = KIND_VOL_CHAR;
        res_char   = 8'd0;
        time_we    = 1'b0;
        speed_we   = 1'b0;
        unique case (phase_eff)
            PH_HEADER: begin
                if (count_eff < HDR_CHECK_LEN && in_byte_reg != HDR_TEXT[count_eff[3:0]]) begin
                    phase_next = PH_HALT;
                    res_valid  = 1'b1;
                    res_kind   = KIND_BAD_HEADER;
                end else if (count_eff + 5'd1 >= HDR_SKIP_TO) begin
                    count_next = 5'd0;
                    phase_next = PH_VOL_NAME;
                end else begin
                    count_next = count_eff + 5'd1;
                end
            end
            PH_VOL_NAME: begin
                res_valid = 1'b1;
                if (in_byte_reg != NUL) begin
                    res_kind = KIND_VOL_CHAR;
                    res_char = in_byte_reg;
                end else begin
                    res_kind   = KIND_VOL_END;
                    phase_next = PH_VOL_PAD;
                    count_next = 5'd0;
                end
            end
            PH_VOL_PAD, PH_FILE_PAD: begin
                if (count_eff + 5'd1 >= PAD_LEN) begin
                    count_next = 5'd0;
                    phase_next = (phase_eff == PH_VOL_PAD) ? PH_FILE_NAME : PH_REC_TYPE;
                end else begin
                    count_next = count_eff + 5'd1;
                end
            end
            PH_FILE_NAME: begin
                res_valid = 1'b1;
                if (in_byte_reg != NUL) begin
                    res_kind = KIND_FILE_CHAR;
                    res_char = in_byte_reg;
                end else begin
                    res_kind   = KIND_FILE_END;
                    phase_next = PH_FILE_PAD;
                    count_next = 5'd0;
                end
            end
            PH_REC_TYPE: begin
                if (in_byte_reg == REC_AUDIO || in_byte_reg == REC_MOVIE) begin
                    movie_next = in_byte_reg[0];
                    count_next = 5'd1;
                    phase_next = PH_REC_BODY;
                end else if (in_byte_reg == LIST_FF) begin
                    phase_next = PH_AFTER_FF;
                    res_valid  = 1'b1;
                    res_kind   = KIND_ENTRY_END;
                end else begin
                    phase_next = PH_HALT;
                    res_valid  = 1'b1;
                    res_kind   = KIND_BAD_TYPE;
                end
            end
            PH_REC_BODY: begin
                time_we  = count_eff >= TIME_FIRST && count_eff <= TIME_LAST;
                speed_we = count_eff == SPEED_OFF;
                if (count_eff < rec_last) begin
                    count_next = count_eff + 5'd1;
                end else begin
                    count_next = 5'd0;
                    phase_next = PH_REC_TYPE;
                    res_valid  = 1'b1;
                    res_kind   = movie_reg ? KIND_MOVIE : KIND_AUDIO;
                end
            end
            PH_AFTER_FF: begin
                if (in_byte_reg != NUL) begin
                    phase_next = PH_FILE_NAME;
                    res_valid  = 1'b1;
                    res_kind   = KIND_FILE_CHAR;
                    res_char   = in_byte_reg;
                end else begin
                    phase_next = PH_AFTER_VOL;
                end
            end
            PH_AFTER_VOL: begin
                res_valid = 1'b1;
                if (in_byte_reg != NUL) begin
                    phase_next = PH_VOL_NAME;
                    res_kind   = KIND_VOL_CHAR;
                    res_char   = in_byte_reg;
                end else begin
                    phase_next = PH_HALT;
                    res_kind   = KIND_LIST_END;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_speed = 9'd0;
        res_inter = 8'd0;
        if (res_kind == KIND_AUDIO) begin
            res_speed = {1'b0, speed_reg} + 9'd1;
            res_inter = in_byte_reg;
        end
        if (res_kind == KIND_AUDIO || res_kind == KIND_MOVIE) begin
            res_data = {7'd0, res_inter, res_speed, time_reg[3], time_reg[4], time_reg[5],
                        time_reg[0], time_reg[1], time_reg[2], res_char};
        end else begin
            res_data = {72'd0, res_char};
        end
    end

    assign out_valid_next = proc ? res_valid : (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            count_reg     <= 5'd0;
            movie_reg     <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (proc) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                movie_reg <= movie_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
        if (proc && res_valid) begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
        end
        if (proc && time_we) begin
            time_reg[time_idx] <= in_byte_reg;
        end
        if (proc && speed_we) begin
            speed_reg <= in_byte_reg;
        end
    end

    a_char_only_for_names: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != KIND_VOL_CHAR && out_kind_reg != KIND_FILE_CHAR
        |-> out_data_reg[7:0] == 8'd0)
        else $error("name_char set on a non-character result");

    a_speed_only_audio: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != KIND_AUDIO |-> out_data_reg[72:56] == 17'd0)
        else $error("speed or interleave set on a non-audio result");

    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_REC_BODY |-> count_reg >= 5'd1 && count_reg <= MOVIE_LAST)
        else $error("record byte count out of range");

    a_halt_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && res_valid && (res_kind == KIND_BAD_HEADER || res_kind == KIND_BAD_TYPE)
        |=> phase_reg == PH_HALT)
        else $error("parser did not halt after an error result");

    a_result_after_proc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(proc && res_valid))
        else $error("result appeared without a processed beat");

endmodule

[verif/xlrp_tb_pkg.sv]
`timescale 1ns / 1ps

package xlrp_tb_pkg;

    import xlrp_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] name_char;
        logic [7:0] start_minute;
        logic [7:0] start_second;
        logic [7:0] start_frame;
        logic [7:0] end_minute;
        logic [7:0] end_second;
        logic [7:0] end_frame;
        logic [8:0] speed_factor;
        logic [7:0] interleave;
    } list_event_t;

    class list_event_tracker;

        phase_t      ph;
        logic [4:0]  cnt;
        logic        is_movie;
        logic [7:0]  stamp [6];
        logic [7:0]  speed_raw;

        list_event_t expected_q [$];
        int unsigned errors;
        int unsigned live_beats;

        function new();
            ph         = PH_IDLE;
            cnt        = '0;
            is_movie   = 1'b0;
            speed_raw  = '0;
            errors     = 0;
            live_beats = 0;
            foreach (stamp[i]) stamp[i] = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void count_error(string msg);
            errors++;
            if (errors <= 10) $display("tb_top: mismatch: %s", msg);
        endfunction

        function void note_byte(logic [7:0] b, logic first);
            list_event_t e;
            bit          emit;
            e    = '0;
            emit = 1'b0;
            if (first) begin
                ph  = PH_HEADER;
                cnt = '0;
            end
            if (ph != PH_IDLE && ph != PH_HALT) live_beats++;
            case (ph) inside
                PH_HEADER: begin
                    if (cnt < HDR_CHECK_LEN && b != HDR_TEXT[cnt[3:0]]) begin
                        ph     = PH_HALT;
                        e.kind = KIND_BAD_HEADER;
                        emit   = 1'b1;
                    end else begin
                        cnt++;
                        if (cnt >= HDR_SKIP_TO) begin
                            cnt = '0;
                            ph  = PH_VOL_NAME;
                        end
                    end
                end
                PH_VOL_NAME: begin
                    emit = 1'b1;
                    if (b != NUL) begin
                        e.kind      = KIND_VOL_CHAR;
                        e.name_char = b;
                    end else begin
                        e.kind = KIND_VOL_END;
                        ph     = PH_VOL_PAD;
                        cnt    = '0;
                    end
                end
                PH_VOL_PAD, PH_FILE_PAD: begin
                    cnt++;
                    if (cnt >= PAD_LEN) begin
                        cnt = '0;
                        ph  = (ph == PH_VOL_PAD) ? PH_FILE_NAME : PH_REC_TYPE;
                    end
                end
                PH_FILE_NAME: begin
                    emit = 1'b1;
                    if (b != NUL) begin
                        e.kind      = KIND_FILE_CHAR;
                        e.name_char = b;
                    end else begin
                        e.kind = KIND_FILE_END;
                        ph     = PH_FILE_PAD;
                        cnt    = '0;
                    end
                end
                PH_REC_TYPE: begin
                    if (b == REC_AUDIO || b == REC_MOVIE) begin
                        is_movie = (b == REC_MOVIE);
                        cnt      = 5'd1;
                        ph       = PH_REC_BODY;
                    end else if (b == LIST_FF) begin
                        ph     = PH_AFTER_FF;
                        e.kind = KIND_ENTRY_END;
                        emit   = 1'b1;
                    end else begin
                        ph     = PH_HALT;
                        e.kind = KIND_BAD_TYPE;
                        emit   = 1'b1;
                    end
                end
                PH_REC_BODY: begin
                    if (cnt >= TIME_FIRST && cnt <= TIME_LAST) stamp[3'(cnt - TIME_FIRST)] = b;
                    else if (cnt == SPEED_OFF) speed_raw = b;
                    if (cnt < (is_movie ? MOVIE_LAST : AUDIO_LAST)) begin
                        cnt++;
                    end else begin
                        cnt            = '0;
                        ph             = PH_REC_TYPE;
                        emit           = 1'b1;
                        e.kind         = is_movie ? KIND_MOVIE : KIND_AUDIO;
                        e.start_minute = stamp[2];
                        e.start_second = stamp[1];
                        e.start_frame  = stamp[0];
                        e.end_minute   = stamp[5];
                        e.end_second   = stamp[4];
                        e.end_frame    = stamp[3];
                        if (!is_movie) begin
                            e.speed_factor = {1'b0, speed_raw} + 9'd1;
                            e.interleave   = b;
                        end
                    end
                end
                PH_AFTER_FF: begin
                    if (b != NUL) begin
                        ph          = PH_FILE_NAME;
                        e.kind      = KIND_FILE_CHAR;
                        e.name_char = b;
                        emit        = 1'b1;
                    end else begin
                        ph = PH_AFTER_VOL;
                    end
                end
                PH_AFTER_VOL: begin
                    emit = 1'b1;
                    if (b != NUL) begin
                        ph          = PH_VOL_NAME;
                        e.kind      = KIND_VOL_CHAR;
                        e.name_char = b;
                    end else begin
                        ph     = PH_HALT;
                        e.kind = KIND_LIST_END;
                    end
                end
                default: ;
            endcase
            if (emit) expected_q.push_back(e);
        endfunction

        function void cmp(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                count_error($sformatf("%s: expected %0h, got %0h", field, want, got));
        endfunction

        function void check_event(logic [3:0] kind, logic [OUT_DATA_W-1:0] data);
            list_event_t e;
            if (expected_q.size() == 0) begin
                count_error($sformatf("result with nothing pending, kind %0d", kind));
                return;
            end
            e = expected_q.pop_front();
            cmp("kind",         16'(e.kind),         16'(kind));
            cmp("name_char",    16'(e.name_char),    16'(data[7:0]));
            cmp("start_minute", 16'(e.start_minute), 16'(data[15:8]));
            cmp("start_second", 16'(e.start_second), 16'(data[23:16]));
            cmp("start_frame",  16'(e.start_frame),  16'(data[31:24]));
            cmp("end_minute",   16'(e.end_minute),   16'(data[39:32]));
            cmp("end_second",   16'(e.end_second),   16'(data[47:40]));
            cmp("end_frame",    16'(e.end_frame),    16'(data[55:48]));
            cmp("speed_factor", 16'(e.speed_factor), 16'(data[64:56]));
            cmp("interleave",   16'(e.interleave),   16'(data[72:65]));
            cmp("padding",      16'd0,               16'(data[79:73]));
        endfunction

        function void close_out();
            list_event_t e;
            while (expected_q.size() != 0) begin
                e = expected_q.pop_front();
                count_error($sformatf("result never arrived, kind %0d", e.kind));
            end
        endfunction

    endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import xlrp_pkg::*;
    import xlrp_tb_pkg::*;

    localparam int ITEMS      = 1650;
    localparam int IDLE_LIMIT = 1000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [3:0]            m_tuser;

    list_event_tracker board = new();

    logic [8:0]  file_q [$];
    bit          quiet;
    int unsigned idle_cycles;

    always #5 aclk = ~aclk;

    xa_list_record_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) board.check_event(m_tuser, m_tdata);
        end
    end

    initial begin
        int unsigned cycle;
        int          stall;
        cycle = 0;
        stall = 0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (stall == 0 && (cycle % 400) >= 100) stall = gap_len();
            if (stall != 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic first);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    function automatic void add_byte(logic [7:0] b, logic first);
        file_q.push_back({first, b});
    endfunction

    function automatic void add_name(int min_len);
        repeat ($urandom_range(min_len, 4)) add_byte(8'($urandom_range(1, 255)), 1'b0);
        add_byte(NUL, 1'b0);
        repeat (4) add_byte(rand_byte(), 1'b0);
    endfunction

    function automatic void build_file();
        int  n_vol;
        int  n_file;
        bit  movie;
        file_q.delete();
        for (int i = 0; i < 15; i++) add_byte(HDR_TEXT[4'(i)], i == 0);
        repeat (9) add_byte(rand_byte(), 1'b0);
        n_vol = $urandom_range(1, 2);
        for (int v = 0; v < n_vol; v++) begin
            add_name(v == 0 ? 0 : 1);
            n_file = $urandom_range(1, 3);
            for (int f = 0; f < n_file; f++) begin
                add_name(f == 0 ? 0 : 1);
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 19) == 0) begin
                        add_byte(8'($urandom_range(2, 254)), 1'b0);
                        return;
                    end
                    movie = ($urandom_range(0, 1) == 1);
                    add_byte(movie ? REC_MOVIE : REC_AUDIO, 1'b0);
                    repeat (movie ? 12 : 10) add_byte(rand_byte(), 1'b0);
                end
                add_byte(LIST_FF, 1'b0);
            end
            add_byte(NUL, 1'b0);
        end
        add_byte(NUL, 1'b0);
    endfunction

    task automatic play_file(bit damage);
        int idx;
        if (damage) begin
            idx = $urandom_range(1, file_q.size() - 1);
            case ($urandom_range(0, 2))
                0: file_q[idx][7:0] = 8'($urandom_range(0, 255));
                1: file_q[idx][8] = 1'b1;
                default: while (file_q.size() > idx) void'(file_q.pop_back());
            endcase
        end
        foreach (file_q[i]) send_byte(file_q[i][7:0], file_q[i][8]);
    endtask

    initial begin
        int file_no;
        quiet = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h63, 1'b0);
        for (int i = 0; i < 14; i++) send_byte(HDR_TEXT[4'(i)], i == 0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        file_no = 0;
        while (board.live_beats < ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            build_file();
            play_file(file_no > 0 && $urandom_range(0, 9) < 3);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            if (file_no == 2 || $urandom_range(0, 9) == 0) drain_results();
            file_no++;
        end

        drain_results();
        repeat (20) @(posedge aclk);
        board.close_out();
        if (board.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/xlrp_pkg.sv
rtl/xa_list_record_parser.sv
verif/xlrp_tb_pkg.sv
verif/tb_top.sv
